@@ rtl/acwr_pkg.sv @@
// Shared types and constants for the averaged current window reverser.
// Holds command/direction codes, field widths, config reset values and the
// controller/datapath command and status structs. No dependencies.
package acwr_pkg;

	// field widths
	localparam int SAMPLE_W = 12;
	localparam int LEVEL_W  = 13;
	localparam int BLANK_W  = 16;
	localparam int TIME_W   = 32;
	localparam int CMD_W    = 2;
	localparam int DIR_W    = 2;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

	// direction codes
	localparam logic [DIR_W-1:0] DIR_STOPPED = 2'd0;
	localparam logic [DIR_W-1:0] DIR_FWD     = 2'd1;
	localparam logic [DIR_W-1:0] DIR_REV     = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SPEED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLANKING    = 2'd3;

	// configuration reset values
	localparam logic [LEVEL_W-1:0]  RST_DRIVE_SPEED = 13'd0;
	localparam logic [SAMPLE_W-1:0] RST_LOW_THRESH  = 12'd0;
	localparam logic [SAMPLE_W-1:0] RST_HIGH_THRESH = 12'd4095;
	localparam logic [BLANK_W-1:0]  RST_BLANKING    = 16'd300;

	// full-on PWM level; drive saturates here
	localparam logic [LEVEL_W-1:0] PWM_FULL = 13'd4096;

	// controller -> datapath commands
	typedef struct packed {
		logic capture;   // latch the input transaction
		logic rd_issue;  // read the window slot about to be replaced
		logic update;    // update store, sum, fill, slot; load divider
		logic div_step;  // one restoring-divider step
		logic finish;    // commit state changes and load result register
	} acwr_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic run_tick;  // latched item is a tick while running
		logic div_last;  // divider is on its final step
		logic out_free;  // result register can take a new result
	} acwr_sts_t;

endpackage

@@ rtl/acwr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Parameters set width and depth. No dependencies.
module acwr_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 20
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                  wdata,
	input  logic                              re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/acwr_ctrl.sv @@
// Sequencing state machine for the averaged current window reverser.
// Drives acwr_pkg::acwr_cmd_t commands from acwr_pkg::acwr_sts_t status.
// Depends on acwr_pkg.
module acwr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  acwr_pkg::acwr_sts_t sts,
	output acwr_pkg::acwr_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_UPDATE = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.run_tick) begin
					cmd.rd_issue = 1'b1;
					state_d      = ST_UPDATE;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// wait for the result register to drain
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/acwr_dp.sv @@
// Datapath: config registers, window store, running sum, serial divider,
// reversal decision and the result register. Depends on acwr_pkg, acwr_ram.
module acwr_dp #(
	parameter int WINDOW = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  acwr_pkg::acwr_cmd_t                  cmd,
	output acwr_pkg::acwr_sts_t                  sts,
	// configuration
	input  logic                                 cfg_we,
	input  logic [acwr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [acwr_pkg::CFG_W-1:0]           cfg_data,
	// input payload
	input  logic [acwr_pkg::CMD_W-1:0]           command,
	input  logic [acwr_pkg::SAMPLE_W-1:0]        sample,
	input  logic [acwr_pkg::TIME_W-1:0]          now_ms,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 active,
	output logic [acwr_pkg::DIR_W-1:0]           direction,
	output logic [acwr_pkg::LEVEL_W-1:0]         drive_a,
	output logic [acwr_pkg::LEVEL_W-1:0]         drive_b,
	output logic [acwr_pkg::SAMPLE_W-1:0]        average,
	output logic                                 out_of_range,
	output logic                                 in_blanking,
	output logic                                 reversed,
	output logic                                 refused
);

	localparam int SLW = $clog2(WINDOW > 1 ? WINDOW : 2);   // slot index
	localparam int FW  = $clog2(WINDOW + 1);                  // fill count
	localparam int SW  = acwr_pkg::SAMPLE_W + FW;             // window sum
	localparam int CW  = $clog2(SW);                          // divider steps
	localparam logic [SLW-1:0] SLOT_LAST = SLW'(WINDOW - 1);
	localparam logic [FW-1:0]  FILL_FULL = FW'(WINDOW);
	localparam logic [CW-1:0]  STEP_LAST = CW'(SW - 1);

	// configuration registers
	logic [acwr_pkg::LEVEL_W-1:0]  speed_q;
	logic [acwr_pkg::SAMPLE_W-1:0] low_q;
	logic [acwr_pkg::SAMPLE_W-1:0] high_q;
	logic [acwr_pkg::BLANK_W-1:0]  blank_cfg_q;

	// latched input transaction
	logic [acwr_pkg::CMD_W-1:0]    cmd_in_q;
	logic [acwr_pkg::SAMPLE_W-1:0] sample_q;
	logic [acwr_pkg::TIME_W-1:0]   now_q;

	// monitor state
	logic                          running_q;
	logic [acwr_pkg::DIR_W-1:0]    dir_q;
	logic [FW-1:0]                 fill_q;
	logic [SLW-1:0]                slot_q;
	logic [SW-1:0]                 sum_q;
	logic [acwr_pkg::TIME_W-1:0]   last_q;

	// divider
	logic [FW-1:0]                 rem_q;
	logic [SW-1:0]                 quo_q;
	logic [CW-1:0]                 step_q;
	logic [FW:0]                   trial;
	logic                          trial_ge;

	// result register
	logic                          out_valid_q;
	logic                          active_q;
	logic [acwr_pkg::DIR_W-1:0]    dir_out_q;
	logic [acwr_pkg::LEVEL_W-1:0]  drive_a_q;
	logic [acwr_pkg::LEVEL_W-1:0]  drive_b_q;
	logic [acwr_pkg::SAMPLE_W-1:0] avg_out_q;
	logic                          oor_out_q;
	logic                          blank_out_q;
	logic                          rev_out_q;
	logic                          ref_out_q;

	logic [acwr_pkg::SAMPLE_W-1:0] old_sample;
	logic                          full;
	logic [SW-1:0]                 sum_new;

	// finish-stage decision
	logic                          run_tick;
	logic                          is_start;
	logic                          is_stop;
	logic                          refuse;
	logic [acwr_pkg::SAMPLE_W-1:0] avg;
	logic [acwr_pkg::TIME_W-1:0]   elapsed;
	logic                          blank;
	logic                          oor;
	logic                          flip;
	logic                          running_d;
	logic [acwr_pkg::DIR_W-1:0]    dir_d;
	logic [acwr_pkg::LEVEL_W-1:0]  level;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q     <= acwr_pkg::RST_DRIVE_SPEED;
			low_q       <= acwr_pkg::RST_LOW_THRESH;
			high_q      <= acwr_pkg::RST_HIGH_THRESH;
			blank_cfg_q <= acwr_pkg::RST_BLANKING;
		end else if (cfg_we) begin
			case (cfg_index)
				acwr_pkg::REG_DRIVE_SPEED: speed_q <= cfg_data[acwr_pkg::LEVEL_W-1:0];
				acwr_pkg::REG_LOW_THRESH:  low_q   <= cfg_data[acwr_pkg::SAMPLE_W-1:0];
				acwr_pkg::REG_HIGH_THRESH: high_q  <= cfg_data[acwr_pkg::SAMPLE_W-1:0];
				acwr_pkg::REG_BLANKING:    blank_cfg_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input latch
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_in_q <= command;
			sample_q <= sample;
			now_q    <= now_ms;
		end
	end

	// window store; entries past the fill count may be read but their data is never used
	acwr_ram #(
		.WIDTH(acwr_pkg::SAMPLE_W),
		.DEPTH(WINDOW)
	) u_store (
		.clk  (clk),
		.we   (cmd.update),
		.waddr(slot_q),
		.wdata(sample_q),
		.re   (cmd.rd_issue),
		.raddr(slot_q),
		.rdata(old_sample)
	);

	// running sum: oldest sample leaves once the window is full
	assign full    = (fill_q == FILL_FULL);
	assign sum_new = sum_q - (full ? SW'(old_sample) : '0) + SW'(sample_q);

	// restoring divider step: sum / fill
	assign trial    = {rem_q, quo_q[SW-1]};
	assign trial_ge = (trial >= {1'b0, fill_q});

	// decision at finish
	assign run_tick = (cmd_in_q == acwr_pkg::CMD_TICK) && running_q;
	assign is_start = (cmd_in_q == acwr_pkg::CMD_START);
	assign is_stop  = (cmd_in_q == acwr_pkg::CMD_STOP);
	assign refuse   = (is_start && running_q) || (is_stop && !running_q) ||
	                  (!is_start && !is_stop && cmd_in_q != acwr_pkg::CMD_TICK);
	assign avg      = quo_q[acwr_pkg::SAMPLE_W-1:0];
	assign elapsed  = now_q - last_q;
	assign blank    = run_tick && (elapsed < acwr_pkg::TIME_W'(blank_cfg_q));
	assign oor      = run_tick && ((avg < low_q) || (avg > high_q));
	assign flip     = oor && !blank &&
	                  (dir_q == acwr_pkg::DIR_FWD || dir_q == acwr_pkg::DIR_REV);
	assign level    = (speed_q > acwr_pkg::PWM_FULL) ? acwr_pkg::PWM_FULL : speed_q;

	always_comb begin
		running_d = running_q;
		dir_d     = dir_q;
		if (is_start && !running_q) begin
			running_d = 1'b1;
			dir_d     = acwr_pkg::DIR_FWD;
		end else if (is_stop && running_q) begin
			running_d = 1'b0;
			dir_d     = acwr_pkg::DIR_STOPPED;
		end else if (flip) begin
			dir_d = (dir_q == acwr_pkg::DIR_FWD) ? acwr_pkg::DIR_REV : acwr_pkg::DIR_FWD;
		end
	end

	// monitor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			dir_q     <= acwr_pkg::DIR_STOPPED;
			fill_q    <= '0;
			slot_q    <= '0;
			sum_q     <= '0;
			last_q    <= '0;
		end else if (cmd.update) begin
			sum_q  <= sum_new;
			slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
			if (!full) begin
				fill_q <= fill_q + 1'b1;
			end
		end else if (cmd.finish) begin
			running_q <= running_d;
			dir_q     <= dir_d;
			if (is_start && !running_q) begin
				fill_q <= '0;
				slot_q <= '0;
				sum_q  <= '0;
				last_q <= now_q;
			end else if (flip) begin
				last_q <= now_q;
			end
		end
	end

	// divider registers
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			rem_q  <= '0;
			quo_q  <= sum_new;
			step_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= trial_ge ? FW'(trial - {1'b0, fill_q}) : trial[FW-1:0];
			quo_q  <= {quo_q[SW-2:0], trial_ge};
			step_q <= step_q + 1'b1;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			active_q    <= running_d;
			dir_out_q   <= dir_d;
			drive_a_q   <= (dir_d == acwr_pkg::DIR_FWD) ? level : '0;
			drive_b_q   <= (dir_d == acwr_pkg::DIR_REV) ? level : '0;
			avg_out_q   <= run_tick ? avg : '0;
			oor_out_q   <= oor;
			blank_out_q <= blank;
			rev_out_q   <= flip;
			ref_out_q   <= refuse;
		end
	end

	assign sts.run_tick = run_tick;
	assign sts.div_last = (step_q == STEP_LAST);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign active       = active_q;
	assign direction    = dir_out_q;
	assign drive_a      = drive_a_q;
	assign drive_b      = drive_b_q;
	assign average      = avg_out_q;
	assign out_of_range = oor_out_q;
	assign in_blanking  = blank_out_q;
	assign reversed     = rev_out_q;
	assign refused      = ref_out_q;

endmodule

@@ rtl/averaged_current_window_reverser_unit.sv @@
// Averaged current window reverser: motor current monitor top level.
// Input channel (in_valid/in_stall) carries command, sample and now_ms; the
// output channel (out_valid/out_stall) carries one result per transaction.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be
// written only while the block is idle, which the block does not enforce;
// registers take effect on the next transaction. Start/stop and idle ticks go
// through decode and finish; a tick while running also goes through update
// and the one-bit-per-cycle restoring divider that forms sum / fill count.
// One transaction is in the block at a time; in_stall is high from acceptance
// until its result is written to the output register. The output register
// holds a finished result while out_stall is high, and the next transaction
// can be taken and worked on meanwhile; it waits at its last step until the
// register drains.
// Reset (arst_n low) stops the motor, clears the window state and loads the
// configuration defaults; the window store itself needs no clearing because a
// slot's old value only enters the sum once the window has filled.
// Depends on acwr_pkg, acwr_ctrl, acwr_dp, acwr_ram.
module averaged_current_window_reverser_unit #(
	parameter int WINDOW = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [acwr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [acwr_pkg::CFG_W-1:0]     cfg_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [acwr_pkg::CMD_W-1:0]     command,
	input  logic [acwr_pkg::SAMPLE_W-1:0]  sample,
	input  logic [acwr_pkg::TIME_W-1:0]    now_ms,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           active,
	output logic [acwr_pkg::DIR_W-1:0]     direction,
	output logic [acwr_pkg::LEVEL_W-1:0]   drive_a,
	output logic [acwr_pkg::LEVEL_W-1:0]   drive_b,
	output logic [acwr_pkg::SAMPLE_W-1:0]  average,
	output logic                           out_of_range,
	output logic                           in_blanking,
	output logic                           reversed,
	output logic                           refused
);

	acwr_pkg::acwr_cmd_t cmd;
	acwr_pkg::acwr_sts_t sts;

	// sequencer
	acwr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// datapath
	acwr_dp #(
		.WINDOW(WINDOW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.command     (command),
		.sample      (sample),
		.now_ms      (now_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.active      (active),
		.direction   (direction),
		.drive_a     (drive_a),
		.drive_b     (drive_b),
		.average     (average),
		.out_of_range(out_of_range),
		.in_blanking (in_blanking),
		.reversed    (reversed),
		.refused     (refused)
	);

endmodule

@@ bench/acwr_checker.sv @@
// Scoreboard for the averaged current window reverser: follows config writes,
// predicts one result per accepted input transaction and checks the output channel.
// Depends on acwr_pkg.
module acwr_checker #(
	parameter int WINDOW = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [acwr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [acwr_pkg::CFG_W-1:0]     cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [acwr_pkg::CMD_W-1:0]     command,
	input  logic [acwr_pkg::SAMPLE_W-1:0]  sample,
	input  logic [acwr_pkg::TIME_W-1:0]    now_ms,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  active,
	input  logic [acwr_pkg::DIR_W-1:0]     direction,
	input  logic [acwr_pkg::LEVEL_W-1:0]   drive_a,
	input  logic [acwr_pkg::LEVEL_W-1:0]   drive_b,
	input  logic [acwr_pkg::SAMPLE_W-1:0]  average,
	input  logic                  out_of_range,
	input  logic                  in_blanking,
	input  logic                  reversed,
	input  logic                  refused,
	output int                    errors,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                          active;
		logic [acwr_pkg::DIR_W-1:0]    direction;
		logic [acwr_pkg::LEVEL_W-1:0]  drive_a;
		logic [acwr_pkg::LEVEL_W-1:0]  drive_b;
		logic [acwr_pkg::SAMPLE_W-1:0] average;
		logic                          out_of_range;
		logic                          in_blanking;
		logic                          reversed;
		logic                          refused;
	} monitor_result_t;

	// register copies
	logic [acwr_pkg::LEVEL_W-1:0]  speed_reg;
	logic [acwr_pkg::SAMPLE_W-1:0] low_reg;
	logic [acwr_pkg::SAMPLE_W-1:0] high_reg;
	logic [acwr_pkg::BLANK_W-1:0]  blank_reg;

	// monitor state
	bit                            is_running;
	logic [acwr_pkg::DIR_W-1:0]    motor_dir;
	logic [acwr_pkg::SAMPLE_W-1:0] window_samples [WINDOW];
	int unsigned                   held;
	int unsigned                   slot;
	int unsigned                   sum;
	logic [acwr_pkg::TIME_W-1:0]   stamp_ms;

	monitor_result_t expected_results [$];

	// Advance the monitor by one transaction and return the result it produces.
	function automatic monitor_result_t apply_command(logic [acwr_pkg::CMD_W-1:0] cmd,
			logic [acwr_pkg::SAMPLE_W-1:0] smp, logic [acwr_pkg::TIME_W-1:0] t);
		monitor_result_t r;
		logic [acwr_pkg::LEVEL_W-1:0] lvl;
		logic [acwr_pkg::TIME_W-1:0] since;
		r = '0;
		case (cmd)
			acwr_pkg::CMD_START: begin
				if (is_running) begin
					r.refused = 1'b1;
				end else begin
					is_running = 1'b1;
					motor_dir = acwr_pkg::DIR_FWD;
					foreach (window_samples[i]) window_samples[i] = '0;
					held = 0;
					slot = 0;
					sum = 0;
					stamp_ms = t;
				end
			end
			acwr_pkg::CMD_STOP: begin
				if (!is_running) begin
					r.refused = 1'b1;
				end else begin
					is_running = 1'b0;
					motor_dir = acwr_pkg::DIR_STOPPED;
				end
			end
			acwr_pkg::CMD_TICK: begin
				if (is_running) begin
					// full window: oldest sample leaves the sum first
					if (held >= WINDOW) sum -= window_samples[slot];
					window_samples[slot] = smp;
					sum += smp;
					slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
					if (held < WINDOW) held++;
					r.average = acwr_pkg::SAMPLE_W'(sum / held);
					since = t - stamp_ms;
					r.in_blanking = since < acwr_pkg::TIME_W'(blank_reg);
					r.out_of_range = (r.average < low_reg) || (r.average > high_reg);
					if (r.out_of_range && !r.in_blanking &&
							motor_dir != acwr_pkg::DIR_STOPPED) begin
						motor_dir = (motor_dir == acwr_pkg::DIR_FWD) ?
							acwr_pkg::DIR_REV : acwr_pkg::DIR_FWD;
						r.reversed = 1'b1;
						stamp_ms = t;
					end
				end
			end
			default: r.refused = 1'b1;
		endcase
		lvl = (speed_reg > acwr_pkg::PWM_FULL) ? acwr_pkg::PWM_FULL : speed_reg;
		r.active = is_running;
		r.direction = motor_dir;
		r.drive_a = (motor_dir == acwr_pkg::DIR_FWD) ? lvl : '0;
		r.drive_b = (motor_dir == acwr_pkg::DIR_REV) ? lvl : '0;
		return r;
	endfunction

	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : scoreboard
		monitor_result_t oldest;
		if (!arst_n) begin
			speed_reg = acwr_pkg::RST_DRIVE_SPEED;
			low_reg = acwr_pkg::RST_LOW_THRESH;
			high_reg = acwr_pkg::RST_HIGH_THRESH;
			blank_reg = acwr_pkg::RST_BLANKING;
			is_running = 1'b0;
			motor_dir = acwr_pkg::DIR_STOPPED;
			foreach (window_samples[i]) window_samples[i] = '0;
			held = 0;
			slot = 0;
			sum = 0;
			stamp_ms = '0;
			errors = 0;
			expected_results.delete();
			pending = 0;
		end else begin
			// results first, so one accepted this edge cannot match its own input
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with none expected, expected nothing, actual %h",
						$time, {active, direction, drive_a, drive_b, average,
						out_of_range, in_blanking, reversed, refused});
					errors++;
				end else begin
					oldest = expected_results.pop_front();
					check_field("active", oldest.active, active);
					check_field("direction", oldest.direction, direction);
					check_field("drive_a", oldest.drive_a, drive_a);
					check_field("drive_b", oldest.drive_b, drive_b);
					check_field("average", oldest.average, average);
					check_field("out_of_range", oldest.out_of_range, out_of_range);
					check_field("in_blanking", oldest.in_blanking, in_blanking);
					check_field("reversed", oldest.reversed, reversed);
					check_field("refused", oldest.refused, refused);
				end
			end
			// config writes land whenever cfg_we is high; the bench must write only while idle
			if (cfg_we) begin
				case (cfg_index)
					acwr_pkg::REG_DRIVE_SPEED:
						speed_reg = cfg_data[acwr_pkg::LEVEL_W-1:0];
					acwr_pkg::REG_LOW_THRESH:
						low_reg = cfg_data[acwr_pkg::SAMPLE_W-1:0];
					acwr_pkg::REG_HIGH_THRESH:
						high_reg = cfg_data[acwr_pkg::SAMPLE_W-1:0];
					acwr_pkg::REG_BLANKING:
						blank_reg = cfg_data[acwr_pkg::BLANK_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_results.push_back(apply_command(command, sample, now_ms));
			pending = expected_results.size();
		end
	end

endmodule

@@ bench/tb_averaged_current_window_reverser_unit.sv @@
// Top of the averaged current window reverser testbench: clock, reset, config
// writes, input and output pacing, watchdog and verdict.
// Depends on acwr_pkg, averaged_current_window_reverser_unit, acwr_checker.
module tb_averaged_current_window_reverser_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW = 20;
	localparam logic [acwr_pkg::CMD_W-1:0] CMD_INVALID = 2'd3;
	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 1250;
	localparam int PHASES = 10;
	localparam int HOLD_CYCLES = 400;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [acwr_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [acwr_pkg::CFG_W-1:0]      cfg_data;
	logic                            in_valid;
	logic                            in_stall;
	logic [acwr_pkg::CMD_W-1:0]      command;
	logic [acwr_pkg::SAMPLE_W-1:0]   sample;
	logic [acwr_pkg::TIME_W-1:0]     now_ms;
	logic                            out_valid;
	logic                            out_stall;
	logic                            active;
	logic [acwr_pkg::DIR_W-1:0]      direction;
	logic [acwr_pkg::LEVEL_W-1:0]    drive_a;
	logic [acwr_pkg::LEVEL_W-1:0]    drive_b;
	logic [acwr_pkg::SAMPLE_W-1:0]   average;
	logic                            out_of_range;
	logic                            in_blanking;
	logic                            reversed;
	logic                            refused;

	int check_errors;
	int results_pending;
	int idle_cycles = 0;
	bit hold_req = 1'b0;
	bit gaps_on;
	int burst_left;
	logic [acwr_pkg::TIME_W-1:0]   clock_ms;
	logic [acwr_pkg::SAMPLE_W-1:0] level;
	logic [acwr_pkg::SAMPLE_W-1:0] band_lo;
	logic [acwr_pkg::SAMPLE_W-1:0] band_hi;
	int session_items;

	averaged_current_window_reverser_unit #(.WINDOW(WINDOW)) dut (.*);

	acwr_checker #(.WINDOW(WINDOW)) monitor_check (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .command, .sample, .now_ms,
		.out_valid, .out_stall, .active, .direction, .drive_a, .drive_b,
		.average, .out_of_range, .in_blanking, .reversed, .refused,
		.errors(check_errors), .pending(results_pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// no transaction on either channel for too long ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// output side: stretches of varying stall density, plus one long hold on request
	initial begin : receiver
		int unsigned pct;
		int unsigned span;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end else begin
				span = $urandom_range(1, 60);
				case ($urandom_range(0, 3))
					0: pct = 0;
					1: pct = 20;
					2: pct = 60;
					default: pct = 90;
				endcase
				repeat (span) begin
					out_stall <= ($urandom_range(0, 99) < pct);
					@(posedge clk);
				end
			end
		end
	end

	// offer one transaction and return at the edge that accepts it
	task automatic send(input logic [acwr_pkg::CMD_W-1:0] cmd,
			input logic [acwr_pkg::SAMPLE_W-1:0] smp, input logic [acwr_pkg::TIME_W-1:0] t);
		in_valid <= 1'b1;
		command <= cmd;
		sample <= smp;
		now_ms <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic pause_input(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// bursts of back-to-back transactions with random gaps between them
	task automatic send_paced(input logic [acwr_pkg::CMD_W-1:0] cmd,
			input logic [acwr_pkg::SAMPLE_W-1:0] smp, input logic [acwr_pkg::TIME_W-1:0] t);
		if (gaps_on) begin
			if (burst_left == 0) begin
				pause_input($urandom_range(1, 30));
				burst_left = $urandom_range(1, 20);
			end
			burst_left--;
		end
		send(cmd, smp, t);
	endtask

	// wait until every expected result has come back
	task automatic drain();
		pause_input(1);
		while (results_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input logic [acwr_pkg::CFG_W-1:0] spd,
			input logic [acwr_pkg::CFG_W-1:0] lo, input logic [acwr_pkg::CFG_W-1:0] hi,
			input logic [acwr_pkg::CFG_W-1:0] bl);
		cfg_we <= 1'b1;
		cfg_index <= acwr_pkg::REG_DRIVE_SPEED;
		cfg_data <= spd;
		@(posedge clk);
		cfg_index <= acwr_pkg::REG_LOW_THRESH;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= acwr_pkg::REG_HIGH_THRESH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_index <= acwr_pkg::REG_BLANKING;
		cfg_data <= bl;
		@(posedge clk);
		cfg_we <= 1'b0;
		band_lo = lo[acwr_pkg::SAMPLE_W-1:0];
		band_hi = hi[acwr_pkg::SAMPLE_W-1:0];
	endtask

	// millisecond clock: small steps, now and then a jump anywhere
	function automatic logic [acwr_pkg::TIME_W-1:0] next_ms();
		if ($urandom_range(0, 49) == 0)
			clock_ms = $urandom();
		else
			clock_ms = clock_ms + $urandom_range(0, 40);
		return clock_ms;
	endfunction

	// current follows a drifting level so the average wanders in and out of band
	function automatic logic [acwr_pkg::SAMPLE_W-1:0] pick_sample();
		int v;
		if ($urandom_range(0, 11) == 0)
			level = $urandom_range(0, 1) ? acwr_pkg::SAMPLE_W'($urandom_range(0, 4095))
				: acwr_pkg::SAMPLE_W'((int'(band_lo) + int'(band_hi)) / 2);
		case ($urandom_range(0, 9))
			0, 1: return acwr_pkg::SAMPLE_W'($urandom_range(0, 4095));
			9: return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
			default: begin
				v = int'(level) + int'($urandom_range(0, 200)) - 100;
				if (v < 0) v = 0;
				if (v > 4095) v = 4095;
				return acwr_pkg::SAMPLE_W'(v);
			end
		endcase
	endfunction

	task automatic send_noise(input bit motor_on);
		case ($urandom_range(0, 2))
			0: send_paced(CMD_INVALID, acwr_pkg::SAMPLE_W'($urandom()), next_ms());
			1: send_paced(motor_on ? acwr_pkg::CMD_START : acwr_pkg::CMD_STOP,
				acwr_pkg::SAMPLE_W'($urandom()), next_ms());
			default: send_paced(motor_on ? CMD_INVALID : acwr_pkg::CMD_TICK,
				pick_sample(), next_ms());
		endcase
		session_items++;
	endtask

	// start, a run of ticks with a little noise, stop
	task automatic run_session();
		int ticks;
		ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 80) : $urandom_range(1, 25);
		send_paced(acwr_pkg::CMD_START, acwr_pkg::SAMPLE_W'($urandom()), next_ms());
		repeat (ticks) begin
			if ($urandom_range(0, 24) == 0) send_noise(1'b1);
			send_paced(acwr_pkg::CMD_TICK, pick_sample(), next_ms());
		end
		send_paced(acwr_pkg::CMD_STOP, acwr_pkg::SAMPLE_W'($urandom()), next_ms());
		session_items += ticks + 2;
	endtask

	initial begin : stimulus
		logic [acwr_pkg::CFG_W-1:0] spd, lo, hi, bl;
		cfg_we = 1'b0;
		cfg_index = acwr_pkg::REG_DRIVE_SPEED;
		cfg_data = '0;
		in_valid = 1'b0;
		command = acwr_pkg::CMD_TICK;
		sample = '0;
		now_ms = '0;
		arst_n = 1'b0;
		gaps_on = 1'b0;
		burst_left = 0;
		clock_ms = '0;
		level = 12'd2048;
		band_lo = acwr_pkg::RST_LOW_THRESH;
		band_hi = acwr_pkg::RST_HIGH_THRESH;
		session_items = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// defaults: idle tick, refusals, time wrap, full-scale samples
		send(acwr_pkg::CMD_TICK, 12'hFFF, 32'h0000_0000);
		send(acwr_pkg::CMD_STOP, 12'h000, 32'h0000_0001);
		send(CMD_INVALID, 12'hFFF, 32'hFFFF_FFFF);
		send(acwr_pkg::CMD_START, 12'h000, 32'hFFFF_FF00);
		send(acwr_pkg::CMD_START, 12'h000, 32'hFFFF_FF01);
		send(acwr_pkg::CMD_TICK, 12'hFFF, 32'hFFFF_FFFF);
		send(acwr_pkg::CMD_TICK, 12'h000, 32'h0000_0000);
		send(acwr_pkg::CMD_STOP, 12'h000, 32'h0000_0001);
		drain();

		// saturated drive, zero blanking: reverse both ways
		program_regs(16'd8191, 16'd2000, 16'd2100, 16'd0);
		send(acwr_pkg::CMD_START, 12'h000, 32'd5);
		send(acwr_pkg::CMD_TICK, 12'hFFF, 32'd6);
		send(acwr_pkg::CMD_TICK, 12'h000, 32'd6);
		send(acwr_pkg::CMD_TICK, 12'h000, 32'd7);
		send(acwr_pkg::CMD_TICK, 12'h555, 32'd8);
		send(CMD_INVALID, 12'hAAA, 32'd9);
		send(acwr_pkg::CMD_STOP, 12'h000, 32'd10);
		drain();

		// inverted band, blanking edge at exactly blanking_ms
		program_regs(16'd4096, 16'hF000 | 16'd4095, 16'd0, 16'd10);
		send(acwr_pkg::CMD_START, 12'h000, 32'd1000);
		send(acwr_pkg::CMD_TICK, 12'h555, 32'd1009);
		send(acwr_pkg::CMD_TICK, 12'hAAA, 32'd1010);
		send(acwr_pkg::CMD_TICK, 12'h000, 32'd1019);
		send(acwr_pkg::CMD_TICK, 12'hFFF, 32'd1020);
		send(acwr_pkg::CMD_STOP, 12'h000, 32'd1021);
		drain();

		// random phases, each with its own register setting
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin spd = 16'd4096; lo = 16'd1500; hi = 16'd2500; bl = 16'd50; end
				1: begin spd = 16'hFFFF; lo = 16'hFFFF; hi = 16'h0000; bl = 16'hFFFF; end
				2: begin spd = 16'd0; lo = 16'd0; hi = 16'd4095; bl = 16'd0; end
				3: begin spd = 16'd4097; lo = 16'd1000; hi = 16'd1200; bl = 16'd1; end
				default: begin
					case ($urandom_range(0, 2))
						0: spd = 16'd8191;
						1: spd = 16'd4096;
						default: spd = acwr_pkg::CFG_W'($urandom_range(0, 4096));
					endcase
					lo = acwr_pkg::CFG_W'($urandom_range(0, 3000));
					hi = lo + acwr_pkg::CFG_W'($urandom_range(0, 1095));
					lo[15:12] = 4'($urandom());
					hi[15:12] = 4'($urandom());
					case ($urandom_range(0, 3))
						0: bl = 16'd0;
						1: bl = 16'd1;
						default: bl = acwr_pkg::CFG_W'($urandom_range(0, 200));
					endcase
				end
			endcase
			program_regs(spd, lo, hi, bl);
			level = acwr_pkg::SAMPLE_W'((int'(band_lo) + int'(band_hi)) / 2);
			gaps_on = (p % 3) != 0;
			burst_left = 0;
			// first phase: long output hold while input keeps coming
			if (p == 0) hold_req = 1'b1;
			session_items = 0;
			while (session_items < RANDOM_ITEMS / PHASES) begin
				if ($urandom_range(0, 4) == 0) send_noise(1'b0);
				run_session();
			end
			drain();
		end

		// end of run: let the last results out, then a short tail
		pause_input(1);
		while (results_pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (check_errors == 0 && results_pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
